// File: src/ssms_pkg.sv
// ----------------------------------------------------------------------------
// ssms_pkg: shared definitions for the shared-buffer multi-stack unit
// Sizes, field widths, command codes and the request/response structs that
// pass between the stack controller and the memory engine.
// ----------------------------------------------------------------------------
package ssms_pkg;

  // Sizing
  localparam int DEPTH      = 64;
  localparam int NUM_STACKS = 4;
  localparam int DATA_W     = 32;
  localparam int SEL_W      = 2;
  localparam int FILL_W     = 7;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int STK_W  = $clog2(NUM_STACKS);
  localparam int IDX_W  = $clog2(NUM_STACKS + 1);
  localparam int SLICE  = DEPTH / NUM_STACKS;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [DATA_W-1:0] word_t;

  // Command codes of the input transaction
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Memory engine operations
  typedef enum logic [1:0] {
    MEM_READ    = 2'd0,
    MEM_WRITE   = 2'd1,
    MEM_MOVE_UP = 2'd2,
    MEM_MOVE_DN = 2'd3
  } mem_op_t;

  // addr: read/write address; for a move up the current stack end,
  // for a move down the current stack base. count: entries to move.
  typedef struct packed {
    logic    valid;
    mem_op_t op;
    ptr_t    addr;
    ptr_t    count;
    word_t   wdata;
  } mem_req_t;

  typedef struct packed {
    logic  done;
    word_t rdata;
  } mem_rsp_t;

endpackage

// File: src/ssms_mem_engine.sv
// ----------------------------------------------------------------------------
// ssms_mem_engine: entry memory with a block move engine
// Holds the shared entry store and runs single reads, single writes and
// one-slot shifts of a whole stack, one entry moved per cycle.
// ----------------------------------------------------------------------------
module ssms_mem_engine
  import ssms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  word_t mem [DEPTH];

  logic  active_r, active_nxt;
  logic  up_r, up_nxt;
  ptr_t  src_r, src_nxt;
  ptr_t  cnt_r, cnt_nxt;
  ptr_t  pdst_r, pdst_nxt;
  logic  pend_r, pend_nxt;
  logic  done_r, done_nxt;
  word_t rdata_r;

  logic  rd_en;
  ptr_t  rd_addr;
  logic  wr_en;
  ptr_t  wr_addr;
  word_t wr_data;

  // Sequence the move: read one source per cycle, write it in the next cycle
  always_comb begin
    active_nxt = active_r;
    up_nxt     = up_r;
    src_nxt    = src_r;
    cnt_nxt    = cnt_r;
    pdst_nxt   = pdst_r;
    pend_nxt   = 1'b0;
    done_nxt   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = src_r;
    wr_en      = 1'b0;
    wr_addr    = pdst_r;
    wr_data    = rdata_r;
    if (active_r) begin
      if (cnt_r != '0) begin
        rd_en    = 1'b1;
        rd_addr  = src_r;
        pend_nxt = 1'b1;
        pdst_nxt = up_r ? src_r + 1'b1 : src_r - 1'b1;
        src_nxt  = up_r ? src_r - 1'b1 : src_r + 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
      end
      if (pend_r) begin
        wr_en   = 1'b1;
        wr_addr = pdst_r;
        wr_data = rdata_r;
      end
      if (cnt_r == '0 && !pend_r) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end else if (req.valid) begin
      case (req.op)
        MEM_READ: begin
          rd_en    = 1'b1;
          rd_addr  = req.addr;
          done_nxt = 1'b1;
        end
        MEM_WRITE: begin
          wr_en   = 1'b1;
          wr_addr = req.addr;
          wr_data = req.wdata;
        end
        MEM_MOVE_UP: begin
          active_nxt = 1'b1;
          up_nxt     = 1'b1;
          src_nxt    = req.addr - 1'b1;
          cnt_nxt    = req.count;
        end
        MEM_MOVE_DN: begin
          active_nxt = 1'b1;
          up_nxt     = 1'b0;
          src_nxt    = req.addr;
          cnt_nxt    = req.count;
        end
        default: begin
        end
      endcase
    end
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      done_r   <= done_nxt;
    end
  end

  // Move bookkeeping
  always_ff @(posedge clk) begin
    up_r   <= up_nxt;
    src_r  <= src_nxt;
    cnt_r  <= cnt_nxt;
    pdst_r <= pdst_nxt;
  end

  assign rsp = '{done: done_r, rdata: rdata_r};

`ifndef SYNTHESIS
  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !active_r)
    else $error("memory request issued while a move is running");

  a_pend_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> active_r)
    else $error("pending move write outside a move");

  a_move_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && cnt_r == '0 && !pend_r) |=> (done_r && !active_r))
    else $error("drained move did not complete");
`endif

endmodule

// File: src/shared_buffer_multi_stack_unit.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_stack_unit: several LIFO stacks in one entry memory
// Each transaction pushes to or pops from one stack; a push to a full stack
// first shifts neighboring stacks to make room.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears on the out_ ports for one cycle with out_valid, and the receiver
// cannot stall it. A push to a stack with room and an operation on a stack
// index out of range finish in the decode state, a pop once the memory read
// returns. A push to a full stack walks the stacks above it and then, if it
// is still full, the stacks from 1 up to itself, shifting each that can move
// by one slot; each shifted stack is moved entry by entry through the
// single memory move engine. After reset the stacks are empty and the
// unit is ready at once.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack_unit
  import ssms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_cmd,
  input  logic [SEL_W-1:0]         in_stack_sel,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [FILL_W-1:0]        out_stack_fill,
  output logic [FILL_W-1:0]        out_total_fill
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_EXEC    = 8'b0000_0010,
    S_UP      = 8'b0000_0100,
    S_UP_WAIT = 8'b0000_1000,
    S_DN      = 8'b0001_0000,
    S_DN_WAIT = 8'b0010_0000,
    S_RD_WAIT = 8'b0100_0000,
    S_PUSH    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  ptr_t base_r [NUM_STACKS];
  ptr_t base_nxt [NUM_STACKS];
  ptr_t end_r [NUM_STACKS];
  ptr_t end_nxt [NUM_STACKS];
  ptr_t up_bound [NUM_STACKS];
  logic [NUM_STACKS-1:0] full;
  ptr_t total_r, total_nxt;

  logic             cmd_r;
  logic [STK_W-1:0] sel_r;
  logic             sel_ok_r;
  word_t            val_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [STK_W-1:0] idx_s;
  logic [IDX_W-1:0] idx_dec;
  logic [STK_W-1:0] idx_m1;
  ptr_t             sel_base;
  ptr_t             sel_end;
  logic             sel_full;
  logic             sel_empty;

  mem_req_t req;
  mem_rsp_t rsp;

  logic  push_try;
  logic  emit;
  logic  emit_ok;
  word_t emit_val;
  ptr_t  emit_fill;

  logic              out_valid_r;
  logic              out_ok_r;
  word_t             out_popped_r;
  logic [FILL_W-1:0] out_stack_fill_r;
  logic [FILL_W-1:0] out_total_fill_r;

  // Upper bound and full flag of every stack
  always_comb begin
    for (int i = 0; i < NUM_STACKS - 1; i++) begin
      up_bound[i] = base_r[i+1];
    end
    up_bound[NUM_STACKS-1] = PTR_W'(DEPTH);
    for (int i = 0; i < NUM_STACKS; i++) begin
      full[i] = end_r[i] >= up_bound[i];
    end
  end

  // Selected stack and sweep index views
  assign idx_s     = idx_r[STK_W-1:0];
  assign idx_dec   = idx_r - 1'b1;
  assign idx_m1    = idx_dec[STK_W-1:0];
  assign sel_base  = base_r[sel_r];
  assign sel_end   = end_r[sel_r];
  assign sel_full  = full[sel_r];
  assign sel_empty = sel_end == sel_base;

  // Sequencer: decode, sweep up, sweep down, finish push or pop
  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    end_nxt   = end_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    req       = '0;
    push_try  = 1'b0;
    emit      = 1'b0;
    emit_ok   = 1'b0;
    emit_val  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sel_ok_r) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (cmd_r == CMD_POP) begin
          if (sel_empty) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            end_nxt[sel_r] = sel_end - 1'b1;
            total_nxt      = total_r - 1'b1;
            req.valid      = 1'b1;
            req.op         = MEM_READ;
            req.addr       = sel_end - 1'b1;
            state_nxt      = S_RD_WAIT;
          end
        end else if (!sel_full) begin
          push_try = 1'b1;
        end else begin
          idx_nxt   = IDX_W'(NUM_STACKS - 1);
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (idx_r > IDX_W'(sel_r)) begin
          if (!full[idx_s]) begin
            req.valid       = 1'b1;
            req.op          = MEM_MOVE_UP;
            req.addr        = end_r[idx_s];
            req.count       = end_r[idx_s] - base_r[idx_s];
            base_nxt[idx_s] = base_r[idx_s] + 1'b1;
            end_nxt[idx_s]  = end_r[idx_s] + 1'b1;
            state_nxt       = S_UP_WAIT;
          end else begin
            idx_nxt = idx_dec;
          end
        end else if (sel_full) begin
          idx_nxt   = IDX_W'(1);
          state_nxt = S_DN;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_UP_WAIT: begin
        if (rsp.done) begin
          idx_nxt   = idx_dec;
          state_nxt = S_UP;
        end
      end
      S_DN: begin
        if (idx_r <= IDX_W'(sel_r)) begin
          if (end_r[idx_m1] < base_r[idx_s]) begin
            req.valid       = 1'b1;
            req.op          = MEM_MOVE_DN;
            req.addr        = base_r[idx_s];
            req.count       = end_r[idx_s] - base_r[idx_s];
            base_nxt[idx_s] = base_r[idx_s] - 1'b1;
            end_nxt[idx_s]  = end_r[idx_s] - 1'b1;
            state_nxt       = S_DN_WAIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_DN_WAIT: begin
        if (rsp.done) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DN;
        end
      end
      S_RD_WAIT: begin
        if (rsp.done) begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_val  = rsp.rdata;
          state_nxt = S_IDLE;
        end
      end
      S_PUSH: begin
        push_try = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Store the pushed value if the stack has room, else fail
    if (push_try) begin
      emit      = 1'b1;
      state_nxt = S_IDLE;
      if (!sel_full) begin
        req.valid      = 1'b1;
        req.op         = MEM_WRITE;
        req.addr       = sel_end;
        req.wdata      = val_r;
        end_nxt[sel_r] = sel_end + 1'b1;
        total_nxt      = total_r + 1'b1;
        emit_ok        = 1'b1;
      end
    end
  end

  assign emit_fill = sel_ok_r ? end_nxt[sel_r] - base_r[sel_r] : '0;

  // Control state and stack pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        base_r[i] <= PTR_W'(i * SLICE);
        end_r[i]  <= PTR_W'(i * SLICE);
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= emit;
      base_r      <= base_nxt;
      end_r       <= end_nxt;
    end
  end

  // Capture the transaction, advance the sweep index, hold the result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r    <= in_cmd;
      sel_r    <= STK_W'(in_stack_sel);
      sel_ok_r <= int'(in_stack_sel) < NUM_STACKS;
      val_r    <= in_push_value;
    end
    idx_r <= idx_nxt;
    if (emit) begin
      out_ok_r         <= emit_ok;
      out_popped_r     <= emit_val;
      out_stack_fill_r <= FILL_W'(emit_fill);
      out_total_fill_r <= FILL_W'(total_nxt);
    end
  end

  ssms_mem_engine u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_popped_value = out_popped_r;
  assign out_stack_fill   = out_stack_fill_r;
  assign out_total_fill   = out_total_fill_r;

`ifndef SYNTHESIS
  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_layout_chk
    a_layout: assert property (@(posedge clk) disable iff (!rst_n)
      base_r[g] <= end_r[g] && end_r[g] <= up_bound[g])
      else $error("stack pointers out of order");
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= PTR_W'(DEPTH))
    else $error("total fill exceeds memory depth");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_UP_WAIT || state_r == S_DN_WAIT ||
                  state_r == S_RD_WAIT))
    else $error("memory engine finished while nothing was waiting");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> out_popped_value == '0)
    else $error("failed transaction returned data");
`endif

endmodule

// File: bench/stack_checker.sv
// ----------------------------------------------------------------------------
// stack_checker: result predictor and scoreboard for the multi-stack unit
// Watches the command and result channels of the unit. For every accepted
// command it runs its own model of the shared entry memory and the stack
// bounds, including the shift sweeps of a push to a full stack, and queues
// the answer. Each result strobe is compared field by field with the oldest
// queued answer.
// ----------------------------------------------------------------------------
module stack_checker
  import ssms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_cmd,
  input  logic [SEL_W-1:0]         in_stack_sel,
  input  logic signed [DATA_W-1:0] in_push_value,
  input  logic                     out_valid,
  input  logic                     out_ok,
  input  logic signed [DATA_W-1:0] out_popped_value,
  input  logic [FILL_W-1:0]        out_stack_fill,
  input  logic [FILL_W-1:0]        out_total_fill,
  output int                       fail_count,
  output int                       open_count
);

  typedef struct {
    logic               ok;
    logic [DATA_W-1:0]  popped;
    logic [FILL_W-1:0]  stack_fill;
    logic [FILL_W-1:0]  total_fill;
  } stack_answer_t;

  // Model of the shared memory and stack bounds
  word_t slot_mem [DEPTH];
  ptr_t  stk_lo   [NUM_STACKS+1];
  ptr_t  stk_hi   [NUM_STACKS];

  stack_answer_t stack_answers_q [$];
  int            mismatches = 0;

  function automatic logic stack_full(int s);
    return stk_hi[s] >= stk_lo[s+1];
  endfunction

  // Move stack s up by one slot if there is room above it
  function automatic void raise_stack(int s);
    int a;
    if (stk_hi[s] >= stk_lo[s+1]) return;
    for (a = int'(stk_hi[s]); a > int'(stk_lo[s]); a--) slot_mem[a] = slot_mem[a-1];
    stk_lo[s]++;
    stk_hi[s]++;
  endfunction

  // Move stack s down by one slot if the stack below has room
  function automatic void lower_stack(int s);
    int a;
    if (stk_hi[s-1] >= stk_lo[s]) return;
    for (a = int'(stk_lo[s]); a < int'(stk_hi[s]); a++) slot_mem[a-1] = slot_mem[a];
    stk_lo[s]--;
    stk_hi[s]--;
  endfunction

  function automatic void clear_stacks();
    int i;
    for (i = 0; i <= NUM_STACKS; i++) stk_lo[i] = ptr_t'(i * SLICE);
    for (i = 0; i < NUM_STACKS; i++) stk_hi[i] = stk_lo[i];
  endfunction

  // Apply one command to the model and return the expected answer
  function automatic stack_answer_t apply_stack_op(logic cmd, int s, word_t val);
    stack_answer_t ans;
    int            i;
    int            total;
    ans.ok         = 1'b0;
    ans.popped     = '0;
    ans.stack_fill = '0;
    total          = 0;
    if (s < NUM_STACKS) begin
      if (cmd == CMD_PUSH) begin
        if (stack_full(s)) begin
          for (i = NUM_STACKS - 1; i > s; i--) raise_stack(i);
          if (stack_full(s)) begin
            for (i = 1; i <= s; i++) lower_stack(i);
          end
        end
        if (!stack_full(s)) begin
          slot_mem[stk_hi[s]] = val;
          stk_hi[s]++;
          ans.ok = 1'b1;
        end
      end else if (stk_hi[s] > stk_lo[s]) begin
        stk_hi[s]--;
        ans.popped = slot_mem[stk_hi[s]];
        ans.ok     = 1'b1;
      end
      ans.stack_fill = FILL_W'(stk_hi[s] - stk_lo[s]);
    end
    for (i = 0; i < NUM_STACKS; i++) total += int'(stk_hi[i] - stk_lo[i]);
    ans.total_fill = FILL_W'(total);
    return ans;
  endfunction

  initial begin
    foreach (slot_mem[i]) slot_mem[i] = '0;
    clear_stacks();
  end

  // Compare results first, then predict the transaction taken at this edge
  always @(posedge clk) begin
    stack_answer_t exp_ans;
    if (!rst_n) begin
      clear_stacks();
      stack_answers_q.delete();
    end else begin
      if (out_valid) begin
        if (stack_answers_q.size() == 0) begin
          $display("%0t: result with nothing expected: ok=%0b popped=%0d fill=%0d total=%0d",
                   $time, out_ok, out_popped_value, out_stack_fill, out_total_fill);
          mismatches++;
        end else begin
          exp_ans = stack_answers_q.pop_front();
          if (out_ok !== exp_ans.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b",
                     $time, exp_ans.ok, out_ok);
            mismatches++;
          end
          if (out_popped_value !== exp_ans.popped) begin
            $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                     $time, $signed(exp_ans.popped), out_popped_value);
            mismatches++;
          end
          if (out_stack_fill !== exp_ans.stack_fill) begin
            $display("%0t: stack_fill mismatch: expected %0d, actual %0d",
                     $time, exp_ans.stack_fill, out_stack_fill);
            mismatches++;
          end
          if (out_total_fill !== exp_ans.total_fill) begin
            $display("%0t: total_fill mismatch: expected %0d, actual %0d",
                     $time, exp_ans.total_fill, out_total_fill);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        stack_answers_q.push_back(apply_stack_op(in_cmd, int'(in_stack_sel),
                                                 word_t'(in_push_value)));
      end
    end
    fail_count <= mismatches;
    open_count <= stack_answers_q.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for shared_buffer_multi_stack_unit
// Drives a short directed sequence (empty pops, extreme values, LIFO order)
// and then phases of random push/pop traffic with a skewed push ratio and a
// favored stack, so that stacks fill up, neighbors shift and pushes to a
// full memory fail. The sender idles at different rates per phase; all
// checking is done by stack_checker.
// ----------------------------------------------------------------------------
module testbench;
  import ssms_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_cmd = CMD_PUSH;
  logic [SEL_W-1:0]         in_stack_sel = '0;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_popped_value;
  logic [FILL_W-1:0]        out_stack_fill;
  logic [FILL_W-1:0]        out_total_fill;
  int                       fail_count;
  int                       open_count;
  int                       sender_idle_pct = 0;

  localparam int RANDOM_OPS   = 1100;
  localparam int PHASE_LEN    = 110;
  localparam int DRAIN_CYCLES = DEPTH + 8 * NUM_STACKS;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  shared_buffer_multi_stack_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_stack_sel     (in_stack_sel),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_popped_value (out_popped_value),
    .out_stack_fill   (out_stack_fill),
    .out_total_fill   (out_total_fill)
  );

  stack_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_stack_sel     (in_stack_sel),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_popped_value (out_popped_value),
    .out_stack_fill   (out_stack_fill),
    .out_total_fill   (out_total_fill),
    .fail_count       (fail_count),
    .open_count       (open_count)
  );

  // Issue one transaction: idle at random, then hold start until it is taken
  task automatic send_stack_op(logic cmd, logic [SEL_W-1:0] sel, logic [DATA_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_stack_sel  <= sel;
    in_push_value <= val;
    do @(posedge clk); while (busy);
  endtask

  // Random traffic with a given push ratio, leaning toward one stack
  task automatic send_random_op(int push_pct, logic [SEL_W-1:0] hot_sel);
    logic [SEL_W-1:0] sel;
    logic             cmd;
    sel = ($urandom_range(99) < 50) ? hot_sel : SEL_W'($urandom_range(NUM_STACKS - 1));
    cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
    send_stack_op(cmd, sel, $urandom());
  endtask

  initial begin
    int               n;
    int               push_pct;
    logic [SEL_W-1:0] hot_sel;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, extreme values, LIFO order, drain to empty
    for (n = 0; n < NUM_STACKS; n++) send_stack_op(CMD_POP, SEL_W'(n), '0);
    send_stack_op(CMD_PUSH, 2'd0, 32'h7FFF_FFFF);
    send_stack_op(CMD_PUSH, 2'd0, 32'h8000_0000);
    send_stack_op(CMD_PUSH, 2'd1, 32'h0000_0000);
    send_stack_op(CMD_PUSH, 2'd1, 32'hFFFF_FFFF);
    send_stack_op(CMD_PUSH, 2'd2, 32'hAAAA_AAAA);
    send_stack_op(CMD_PUSH, 2'd3, 32'h5555_5555);
    send_stack_op(CMD_POP,  2'd0, 32'hFFFF_FFFF);
    send_stack_op(CMD_POP,  2'd0, '0);
    send_stack_op(CMD_POP,  2'd0, '0);
    send_stack_op(CMD_POP,  2'd1, '0);
    send_stack_op(CMD_POP,  2'd2, '0);
    send_stack_op(CMD_POP,  2'd3, '0);
    send_stack_op(CMD_POP,  2'd1, '0);

    // Random phases: vary sender idling, push ratio and the favored stack
    push_pct = 90;
    hot_sel  = '0;
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ((n / PHASE_LEN) % 4)
          0: sender_idle_pct = 0;
          1: sender_idle_pct = 88;
          2: sender_idle_pct = 8;
          default: sender_idle_pct = 0;
        endcase
        case ($urandom_range(4))
          0: push_pct = 95;
          1: push_pct = 80;
          2: push_pct = 60;
          3: push_pct = 35;
          default: push_pct = 10;
        endcase
        hot_sel = SEL_W'($urandom_range(NUM_STACKS - 1));
      end
      send_random_op(push_pct, hot_sel);
    end
    start <= 1'b0;

    // Drain outstanding results, then settle
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
src/ssms_pkg.sv
src/ssms_mem_engine.sv
src/shared_buffer_multi_stack_unit.sv
bench/stack_checker.sv
bench/testbench.sv
